/* rtl/core/ipoc_pkg.sv */
// Shared widths, state codes and phase codes for the integer power block.
package ipoc_pkg;

	localparam int unsigned OPND_W = 31;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;

	// Sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BIT  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_SQR  = 2'd3;

	// Partial product phases of one 64x64 product on the 32x32 multiplier
	localparam logic [2:0] PH_LL   = 3'd0;
	localparam logic [2:0] PH_LH   = 3'd1;
	localparam logic [2:0] PH_HL   = 3'd2;
	localparam logic [2:0] PH_HH   = 3'd3;
	localparam logic [2:0] PH_LAST = 3'd4;

	localparam logic [WORD_W-1:0] ONE_W   = WORD_W'(1);
	localparam logic [WORD_W-1:0] ZERO_W  = '0;
	localparam logic [WORD_W-1:0] MINUS_1 = '1;

endpackage

/* rtl/core/int_power_overflow_check.sv */
// Integer power by right-to-left square-and-multiply with a signed 64-bit overflow guard.
//
//   channel   ports                       handshake
//   --------  --------------------------  -----------------------------------
//   command   base, exponent              taken when start is high, busy low
//   result    power, overflow             shown for one cycle while done high
//
// One transaction at a time; busy stays high until its result is shown.
// A zero base is answered straight from idle, a zero exponent from the first decision
// step. Otherwise each exponent bit up to the top set bit takes a decision step plus a
// 64x64 product per operation (multiply where set, square while higher bits remain),
// built in phases LL, LH, HL, HH and LAST on one shared 32x32 multiplier.
// An overflow ends the transaction early. Reset clears the sequencer and the
// result strobe; the receiver cannot stall results.
module int_power_overflow_check
	import ipoc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OPND_W-1:0]        base,
	input  logic [OPND_W-1:0]        exponent,
	output logic                     done,
	output logic signed [WORD_W-1:0] power,
	output logic                     overflow
);

	logic [1:0]          state_q;
	logic [2:0]          phase_q;
	logic [OPND_W-1:0]   e_q;
	logic [WORD_W-1:0]   acc_q;
	logic [WORD_W-1:0]   b_q;
	logic [WORD_W-1:0]   pp_q;
	logic [WORD_W-1:0]   prod_q;
	logic                big_q;
	logic                done_q;
	logic [WORD_W-1:0]   power_q;
	logic                overflow_q;

	logic [WORD_W-1:0]   op_a;
	logic [HALF_W-1:0]   a_half;
	logic [HALF_W-1:0]   b_half;
	logic [WORD_W-1:0]   pp_d;
	logic [WORD_W:0]     hi_sum;
	logic [WORD_W-1:0]   prod_d;
	logic                big_d;
	logic                ovf_d;
	logic                last_ph;
	logic                take;
	logic                fin;
	logic                fin_ovf;
	logic [WORD_W-1:0]   fin_val;

	assign take    = start && (state_q == ST_IDLE);
	assign last_ph = (phase_q == PH_LAST);

	// Select operand halves and drive the shared multiplier
	always_comb begin
		op_a   = (state_q == ST_SQR) ? b_q : acc_q;
		a_half = phase_q[1] ? op_a[WORD_W-1:HALF_W] : op_a[HALF_W-1:0];
		b_half = phase_q[0] ? b_q[WORD_W-1:HALF_W] : b_q[HALF_W-1:0];
		pp_d   = WORD_W'(a_half) * WORD_W'(b_half);
	end

	// Fold the registered partial product into the running product
	always_comb begin
		hi_sum = {{(WORD_W-HALF_W+1){1'b0}}, prod_q[WORD_W-1:HALF_W]} + {1'b0, pp_q};
		prod_d = prod_q;
		big_d  = big_q;
		case (phase_q)
			PH_LH: begin
				prod_d = pp_q;
				big_d  = 1'b0;
			end
			PH_HL, PH_HH: begin
				prod_d = {hi_sum[HALF_W-1:0], prod_q[HALF_W-1:0]};
				big_d  = big_q || (hi_sum[WORD_W:HALF_W] != '0);
			end
			PH_LAST: begin
				big_d  = big_q || (pp_q != '0);
			end
			default: begin
				prod_d = prod_q;
				big_d  = big_q;
			end
		endcase
		ovf_d = big_d || prod_d[WORD_W-1];
	end

	// Decide when the transaction ends and what it returns
	always_comb begin
		fin     = 1'b0;
		fin_ovf = 1'b0;
		fin_val = acc_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && (base == '0)) begin
					fin     = 1'b1;
					fin_val = (exponent == '0) ? ONE_W : ZERO_W;
				end
			end
			ST_BIT: begin
				if (e_q == '0) begin
					fin     = 1'b1;
					fin_val = acc_q;
				end
			end
			ST_MUL: begin
				if (last_ph && ovf_d) begin
					fin     = 1'b1;
					fin_ovf = 1'b1;
					fin_val = MINUS_1;
				end else if (last_ph && (e_q == OPND_W'(1))) begin
					fin     = 1'b1;
					fin_val = prod_d;
				end
			end
			ST_SQR: begin
				if (last_ph && ovf_d) begin
					fin     = 1'b1;
					fin_ovf = 1'b1;
					fin_val = MINUS_1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LL;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			unique case (state_q)
				ST_IDLE: begin
					phase_q <= PH_LL;
					if (take && !fin) begin
						state_q <= ST_BIT;
					end
				end
				ST_BIT: begin
					phase_q <= PH_LL;
					if (fin) begin
						state_q <= ST_IDLE;
					end else if (e_q[0]) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_MUL: begin
					if (!last_ph) begin
						phase_q <= phase_q + 3'd1;
					end else if (fin) begin
						state_q <= ST_IDLE;
					end else begin
						phase_q <= PH_LL;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (!last_ph) begin
						phase_q <= phase_q + 3'd1;
					end else if (fin) begin
						state_q <= ST_IDLE;
					end else begin
						phase_q <= PH_LL;
						state_q <= ST_BIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold operands, partial products and the result
	always_ff @(posedge clk) begin
		pp_q   <= pp_d;
		prod_q <= prod_d;
		big_q  <= big_d;
		if (take) begin
			b_q   <= {{(WORD_W-OPND_W){1'b0}}, base};
			e_q   <= exponent;
			acc_q <= ONE_W;
		end else if ((state_q == ST_MUL) && last_ph && !ovf_d) begin
			acc_q <= prod_d;
		end else if ((state_q == ST_SQR) && last_ph && !ovf_d) begin
			b_q <= prod_d;
			e_q <= e_q >> 1;
		end
		if (fin) begin
			power_q    <= fin_val;
			overflow_q <= fin_ovf;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign power    = power_q;
	assign overflow = overflow_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a transaction is still in flight");

	a_ovf_minus1: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (power == MINUS_1))
		else $error("overflow result is not minus one");

	a_ok_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !overflow) |-> !power[WORD_W-1])
		else $error("non-overflow result outside signed 64-bit range");

	a_zero_base: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (base == '0)) |=> (done && !busy && !overflow))
		else $error("zero base did not answer in one cycle");
`endif

endmodule
